FILE: rtl/aprd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants for the peak and RMS level meter.
package aprd_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int SMP_W    = 24;
  localparam int SPP_W    = 18;
  localparam int FRAME_W  = 40;
  localparam int SUM_W    = 64;
  localparam int SQ_W     = 2 * SMP_W;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int SREM_W   = ROOT_W + 3;

  // Configuration register indexes
  localparam logic REG_SPP   = 1'b0;
  localparam logic REG_FLOOR = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/audio_peak_rms_decimator.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-channel peak and RMS level meter: one result item for each accepted sample item. The
// block works on one item at a time with bit-serial units: a shift-add squarer and a
// restoring frame-position modulo run side by side, then the update state follows. When the
// sample closes a point, a restoring divide of the 64-bit sum of squares by samples_per_point
// and a two-bits-per-cycle square root follow, so such an item takes longer. A finished
// result sits in the output register while the next item is accepted. Configuration writes
// are always ready; issue them only while no item is in flight.
module audio_peak_rms_decimator
  import aprd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [SMP_W-1:0]    cfg_data,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic [3:0]          channel,
  input  wire logic signed [SMP_W-1:0] sample,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output logic                     point_valid,
  output logic [SMP_W-1:0]         point_rms,
  output logic [SMP_W-1:0]         point_peak,
  output logic [SMP_W-1:0]         peak_level,
  output logic [FRAME_W-1:0]       peak_frame
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MULMOD = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_SQRT   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic [6:0] MUL_LAST  = 7'(SMP_W - 1);
  localparam logic [6:0] MOD_LAST  = 7'(FRAME_W - 1);
  localparam logic [6:0] DIV_LAST  = 7'(SUM_W - 1);
  localparam logic [6:0] SQRT_LAST = 7'(ROOT_W - 1);

  logic [2:0]             state;
  logic [6:0]             cnt;
  logic [SPP_W-1:0]       samples_per_point;
  logic [SMP_W-1:0]       level_floor;

  logic [FRAME_W-1:0]     frame_position  [CHANNELS];
  logic [SUM_W-1:0]       square_sum      [CHANNELS];
  logic [SMP_W-1:0]       window_peak     [CHANNELS];
  logic [SMP_W-1:0]       max_level       [CHANNELS];
  logic [FRAME_W-1:0]     max_level_frame [CHANNELS];

  logic [CH_W-1:0]        ch;
  logic [SMP_W-1:0]       mag;
  logic [SMP_W-1:0]       mplier;
  logic [SQ_W-1:0]        acc;
  logic [SPP_W-1:0]       spp;
  logic [FRAME_W-1:0]     pos_sh;
  logic [SPP_W-1:0]       rem;
  logic [SUM_W-1:0]       work;
  logic [SREM_W-1:0]      srem;
  logic [ROOT_W-1:0]      root;

  logic                   r_pv;
  logic [SMP_W-1:0]       r_pp;
  logic [SMP_W-1:0]       r_rms;
  logic [SMP_W-1:0]       r_pl;
  logic [FRAME_W-1:0]     r_pf;

  // Input-side combinational terms
  logic [SMP_W-1:0]       raw_mag;
  logic [SMP_W-1:0]       in_mag;
  logic                   in_range;
  logic                   req_take;
  logic [SPP_W:0]         rem_sh;
  logic [SPP_W:0]         rem_dif;
  logic                   rem_ge;
  logic [SUM_W:0]         sum_add;
  logic [SUM_W-1:0]       sum_next;
  logic [SMP_W-1:0]       wp_next;
  logic                   max_hit;
  logic [SREM_W-1:0]      srem_sh;
  logic [SREM_W-1:0]      strial;
  logic                   s_ge;
  logic                   out_free;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;

  always_comb begin
    raw_mag  = sample[SMP_W-1] ? (~sample + 1'b1) : sample;
    in_mag   = (raw_mag < level_floor) ? level_floor : raw_mag;
    in_range = ({1'b0, channel} < 5'(CHANNELS));

    // One restoring step, shared by the modulo and the divide
    rem_sh  = {rem, (state == S_DIV) ? work[SUM_W-1] : pos_sh[FRAME_W-1]};
    rem_dif = rem_sh - {1'b0, spp};
    rem_ge  = !rem_dif[SPP_W];

    sum_add  = {1'b0, square_sum[ch]} + {{(SUM_W-SQ_W+1){1'b0}}, acc};
    sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    wp_next  = (mag > window_peak[ch]) ? mag : window_peak[ch];
    max_hit  = (mag > max_level[ch]);

    srem_sh = {srem[SREM_W-3:0], work[SUM_W-1:SUM_W-2]};
    strial  = {1'b0, root, 2'b01};
    s_ge    = (srem_sh >= strial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      cnt               <= '0;
      samples_per_point <= SPP_W'(1);
      level_floor       <= SMP_W'(8);
      res_valid         <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        frame_position[i]  <= '0;
        square_sum[i]      <= '0;
        window_peak[i]     <= '0;
        max_level[i]       <= '0;
        max_level_frame[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPP:   samples_per_point <= cfg_data[SPP_W-1:0];
          REG_FLOOR: level_floor       <= cfg_data;
          default:   ;
        endcase
      end

      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_take) begin
            ch     <= channel[CH_W-1:0];
            mag    <= in_mag;
            mplier <= in_mag;
            acc    <= '0;
            rem    <= '0;
            cnt    <= '0;
            spp    <= (samples_per_point == '0) ? SPP_W'(1) : samples_per_point;
            pos_sh <= frame_position[channel[CH_W-1:0]];
            if (in_range) begin
              state <= S_MULMOD;
            end else begin
              r_pv  <= 1'b0;
              r_rms <= '0;
              r_pp  <= '0;
              r_pl  <= '0;
              r_pf  <= '0;
              state <= S_DONE;
            end
          end
        end

        S_MULMOD: begin
          if (cnt <= MUL_LAST) begin
            acc    <= {acc[SQ_W-2:0], 1'b0} + (mplier[SMP_W-1] ? {{SMP_W{1'b0}}, mag} : '0);
            mplier <= {mplier[SMP_W-2:0], 1'b0};
          end
          rem    <= rem_ge ? rem_dif[SPP_W-1:0] : rem_sh[SPP_W-1:0];
          pos_sh <= {pos_sh[FRAME_W-2:0], 1'b0};
          cnt    <= cnt + 1'b1;
          if (cnt == MOD_LAST) begin
            state <= S_UPDATE;
          end
        end

        S_UPDATE: begin
          frame_position[ch] <= frame_position[ch] + 1'b1;
          if (max_hit) begin
            max_level[ch]       <= mag;
            max_level_frame[ch] <= frame_position[ch];
          end
          r_pl  <= max_hit ? mag : max_level[ch];
          r_pf  <= max_hit ? frame_position[ch] : max_level_frame[ch];
          r_pp  <= (rem == '0) ? wp_next : '0;
          r_pv  <= (rem == '0);
          r_rms <= '0;
          cnt   <= '0;
          if (rem == '0) begin
            // Close the point: clear and divide the sum
            square_sum[ch]  <= '0;
            window_peak[ch] <= '0;
            work            <= sum_next;
            state           <= S_DIV;
          end else begin
            square_sum[ch]  <= sum_next;
            window_peak[ch] <= wp_next;
            state           <= S_DONE;
          end
        end

        S_DIV: begin
          rem  <= rem_ge ? rem_dif[SPP_W-1:0] : rem_sh[SPP_W-1:0];
          work <= {work[SUM_W-2:0], rem_ge};
          if (cnt == DIV_LAST) begin
            cnt   <= '0;
            srem  <= '0;
            root  <= '0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        S_SQRT: begin
          srem <= s_ge ? (srem_sh - strial) : srem_sh;
          root <= {root[ROOT_W-2:0], s_ge};
          work <= {work[SUM_W-3:0], 2'b00};
          cnt  <= cnt + 1'b1;
          if (cnt == SQRT_LAST) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            point_valid <= r_pv;
            point_rms   <= r_rms;
            point_peak  <= r_pp;
            peak_level  <= r_pl;
            peak_frame  <= r_pf;
            res_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // Saturate the finished root into the result
      if (state == S_SQRT && cnt == SQRT_LAST) begin
        r_rms <= (root[ROOT_W-2:SMP_W-1] != '0) ? {SMP_W{1'b1}}
                                                : {root[SMP_W-2:0], s_ge};
      end
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> req_stall)
    else $error("input taken while busy");

  a_sqrt_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> (cnt <= SQRT_LAST))
    else $error("root counter overran");

  a_div_only_on_point: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && rem != '0) |=> (state == S_DONE))
    else $error("divide started without a closed point");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
